@@ src/fgtc_pkg.sv @@
// Shared types, constants and helper functions for the fuzzy green-time controller.
`default_nettype none
package fgtc_pkg;

   localparam int GradeBits = 8;
   localparam int GradeOne = 1 << GradeBits;
   localparam int GW = GradeBits + 1;           // grade width, holds GradeOne
   localparam int TW = GW + 2;                  // sum of three grades
   localparam int NW = 8 + GW + 2 + 8;          // weighted numerator times 256
   localparam int QW = 16;                      // quotient width

   // Reciprocals of the ramp widths, rounded up. With this shift the product
   // truncates to the exact quotient for any 8-bit numerator.
   localparam int RecipShift = GradeBits + 13;
   localparam int RecipW = RecipShift - 3;
   localparam int Recip15 = ((1 << RecipShift) + 14) / 15;
   localparam int Recip20 = ((1 << RecipShift) + 19) / 20;
   localparam int Recip25 = ((1 << RecipShift) + 24) / 25;

   // Register indexes.
   localparam logic [2:0] RegCentreShort  = 3'd0;
   localparam logic [2:0] RegCentreMedium = 3'd1;
   localparam logic [2:0] RegCentreLong   = 3'd2;
   localparam logic [2:0] RegFallback     = 3'd3;
   localparam logic [2:0] RegShortLimit   = 3'd4;
   localparam logic [2:0] RegMediumLimit  = 3'd5;

   localparam logic [1:0] ClassShort  = 2'd0;
   localparam logic [1:0] ClassMedium = 2'd1;
   localparam logic [1:0] ClassLong   = 2'd2;

   typedef struct packed {
      logic [7:0] centre_short;
      logic [7:0] centre_medium;
      logic [7:0] centre_long;
      logic [7:0] fallback_seconds;
      logic [7:0] short_limit;
      logic [7:0] medium_limit;
   } cfg_type;

   typedef logic [GW-1:0] grade_type;

   // Rising or falling ramp: num * ONE / den for a fixed small den, done as a
   // multiplication by the reciprocal of den and a shift.
   function automatic grade_type ramp(input logic [7:0] num, input int Den);
      logic [RecipW-1:0] recip;
      logic [8+GradeBits+RecipW-1:0] product;
      case (Den)
         15:      recip = RecipW'(Recip15);
         20:      recip = RecipW'(Recip20);
         25:      recip = RecipW'(Recip25);
         default: recip = '0;
      endcase
      product = {num, {GradeBits{1'b0}}} * recip;
      return GW'(product >> RecipShift);
   endfunction

   // Three grades of one input against fixed breakpoints.
   function automatic logic [3*GW-1:0] fuzzify(input logic [7:0] x,
      input int Lf, input int Lz, input int M0, input int Mp, input int M1,
      input int H0, input int Hf);
      grade_type gl, gm, gh;
      gl = '0; gm = '0; gh = '0;
      if (x <= 8'(Lf)) gl = GW'(GradeOne);
      else if (x < 8'(Lz)) gl = ramp(8'(Lz) - x, Lz - Lf);
      if (x > 8'(M0) && x <= 8'(Mp)) gm = ramp(x - 8'(M0), Mp - M0);
      else if (x > 8'(Mp) && x < 8'(M1)) gm = ramp(8'(M1) - x, M1 - Mp);
      if (x > 8'(H0) && x < 8'(Hf)) gh = ramp(x - 8'(H0), Hf - H0);
      else if (x >= 8'(Hf)) gh = GW'(GradeOne);
      return {gh, gm, gl};
   endfunction

   function automatic grade_type gmin(input grade_type a, input grade_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic grade_type gmax(input grade_type a, input grade_type b);
      return (a > b) ? a : b;
   endfunction

endpackage
`default_nettype wire

@@ src/fuzzy_green_time_controller.sv @@
// Top level of the fuzzy green-time controller.
//  channel | direction | payload
//  req     | in        | tdata[7:0] traffic_density, tdata[15:8] wait_seconds
//  rsp     | out       | tdata[15:0] green_time, tdata[17:16] duration_class
//  csr     | in        | six 8-bit registers at byte addresses 0..20
// The pipeline has three fuzzy and weighting stages, four divider stages of
// four quotient bits each, and one class stage. One request enters per cycle
// unless the output stalls. The pipeline advances only when the output register
// is empty or taken, so a stall freezes every stage and nothing is lost or repeated.
// Reset is synchronous and clears valid bits and the registers to their defaults.
`default_nettype none
module fuzzy_green_time_controller (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // traffic_density, wait_seconds
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // green_time, duration_class, zero fill
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import fgtc_pkg::*;

   cfg_type cfg;
   logic advance, fv;
   logic [NW-1:0] num;
   logic [TW-1:0] total;
   logic [15:0] green;
   logic [1:0] cls;

   assign advance = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign rsp_tdata = {6'd0, cls, green};

   fgtc_regs u_regs (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg
   );

   fgtc_front u_front (
      .clock, .reset, .advance, .in_valid(req_tvalid),
      .density(req_tdata[7:0]), .wait_s(req_tdata[15:8]), .cfg,
      .out_valid(fv), .num, .total
   );

   fgtc_div u_div (
      .clock, .reset, .advance, .in_valid(fv), .num, .total, .cfg,
      .out_valid(rsp_tvalid), .green, .cls
   );
endmodule
`default_nettype wire

@@ src/fgtc_regs.sv @@
// Configuration register file behind the APB-style port.
`default_nettype none
module fgtc_regs (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_psel,
   input  wire logic           csr_penable,
   input  wire logic           csr_pwrite,
   input  wire logic [4:0]     csr_paddr,
   input  wire logic [31:0]    csr_pwdata,
   output logic      [31:0]    csr_prdata,
   output logic                csr_pready,
   output fgtc_pkg::cfg_type   cfg
);
   import fgtc_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic [2:0] idx;
   logic wr;

   assign idx = csr_paddr[4:2];
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            RegCentreShort:  cfg_in.centre_short = csr_pwdata[7:0];
            RegCentreMedium: cfg_in.centre_medium = csr_pwdata[7:0];
            RegCentreLong:   cfg_in.centre_long = csr_pwdata[7:0];
            RegFallback:     cfg_in.fallback_seconds = csr_pwdata[7:0];
            RegShortLimit:   cfg_in.short_limit = csr_pwdata[7:0];
            RegMediumLimit:  cfg_in.medium_limit = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Read mux.
   always_comb begin
      case (idx)
         RegCentreShort:  csr_prdata = {24'd0, cfg_ff.centre_short};
         RegCentreMedium: csr_prdata = {24'd0, cfg_ff.centre_medium};
         RegCentreLong:   csr_prdata = {24'd0, cfg_ff.centre_long};
         RegFallback:     csr_prdata = {24'd0, cfg_ff.fallback_seconds};
         RegShortLimit:   csr_prdata = {24'd0, cfg_ff.short_limit};
         RegMediumLimit:  csr_prdata = {24'd0, cfg_ff.medium_limit};
         default:         csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{centre_short: 8'd25, centre_medium: 8'd45, centre_long: 8'd70,
                     fallback_seconds: 8'd30, short_limit: 8'd35, medium_limit: 8'd60};
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule
`default_nettype wire

@@ src/fgtc_front.sv @@
// Fuzzification, rule evaluation and weighted sum stages.
`default_nettype none
module fgtc_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic                   in_valid,
   input  wire logic [7:0]             density,
   input  wire logic [7:0]             wait_s,
   input  fgtc_pkg::cfg_type           cfg,
   output logic                        out_valid,
   output logic [fgtc_pkg::NW-1:0]     num,
   output logic [fgtc_pkg::TW-1:0]     total
);
   import fgtc_pkg::*;

   // Stage 1: grades.
   logic v1_ff;
   logic [3*GW-1:0] d_ff, w_ff;
   // Stage 2: rule outputs.
   logic v2_ff;
   grade_type gs_ff, gm_ff, gl_ff;
   // Stage 3: products and sum.
   logic v3_ff;
   logic [NW-1:0] num_ff;
   logic [TW-1:0] total_ff;

   grade_type dl, dm, dh, wl, wm, wh;
   assign {dh, dm, dl} = d_ff;
   assign {wh, wm, wl} = w_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid; v2_ff <= v1_ff; v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_ff <= fuzzify(density, 25, 40, 30, 50, 70, 60, 75);
         w_ff <= fuzzify(wait_s, 20, 40, 30, 55, 80, 70, 90);
         gs_ff <= gmax(gmax(gmin(dl, wl), gmin(dl, wm)), gmin(dm, wl));
         gm_ff <= gmax(gmax(gmin(dm, wm), gmin(dm, wh)), gmax(gmin(dh, wl), gmin(dl, wh)));
         gl_ff <= gmax(gmin(dh, wm), gmin(dh, wh));
         num_ff <= NW'({(NW-8)'(cfg.centre_short * gs_ff + cfg.centre_medium * gm_ff
                    + cfg.centre_long * gl_ff), 8'd0});
         total_ff <= TW'(gs_ff) + TW'(gm_ff) + TW'(gl_ff);
      end
   end

   assign out_valid = v3_ff;
   assign num = num_ff;
   assign total = total_ff;
endmodule
`default_nettype wire

@@ src/fgtc_div.sv @@
// Pipelined restoring divider with rounding, fallback and classification.
`default_nettype none
module fgtc_div (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic                   in_valid,
   input  wire logic [fgtc_pkg::NW-1:0] num,
   input  wire logic [fgtc_pkg::TW-1:0] total,
   input  fgtc_pkg::cfg_type           cfg,
   output logic                        out_valid,
   output logic [15:0]                 green,
   output logic [1:0]                  cls
);
   import fgtc_pkg::*;

   // Four quotient bits are resolved per stage.
   localparam int BitsPerStage = 4;
   localparam int Stages = QW / BitsPerStage;
   localparam int RW = TW + 1;

   logic              v_ff   [Stages+1];
   logic [NW-1:0]     n_ff   [Stages+1];   // dividend, remaining bits shift out
   logic [RW-1:0]     r_ff   [Stages+1];
   logic [QW-1:0]     q_ff   [Stages+1];
   logic [TW-1:0]     t_ff   [Stages+1];
   logic              v_out_ff;
   logic [15:0]       green_ff;
   logic [1:0]        cls_ff;

   // Rounded dividend: num + total/2. Quotient fits in QW bits.
   logic [NW:0] rounded;
   assign rounded = {1'b0, num} + (NW+1)'(total >> 1);

   always_comb begin
      v_ff[0] = in_valid;
      n_ff[0] = rounded[NW-1:0];
      t_ff[0] = total;
      r_ff[0] = RW'(rounded[NW:QW]);   // top bits are below total whenever total is nonzero
      q_ff[0] = '0;
   end

   for (genvar s = 0; s < Stages; s++) begin : g_stage
      logic [RW-1:0] r_next;
      logic [QW-1:0] q_next;
      logic [NW-1:0] n_next;
      always_comb begin
         logic [RW:0] trial;
         r_next = r_ff[s];
         q_next = q_ff[s];
         n_next = n_ff[s];
         for (int b = 0; b < BitsPerStage; b++) begin
            trial = {r_next, n_next[QW-1]};
            n_next = n_next << 1;
            if (trial >= (RW+1)'(t_ff[s])) begin
               r_next = RW'(trial - (RW+1)'(t_ff[s]));
               q_next = {q_next[QW-2:0], 1'b1};
            end else begin
               r_next = RW'(trial);
               q_next = {q_next[QW-2:0], 1'b0};
            end
         end
      end
      logic v_s_ff;
      logic [RW-1:0] r_s_ff;
      logic [QW-1:0] q_s_ff;
      logic [NW-1:0] n_s_ff;
      logic [TW-1:0] t_s_ff;
      always_ff @(posedge clock) begin
         if (reset) v_s_ff <= 1'b0;
         else if (advance) v_s_ff <= v_ff[s];
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            r_s_ff <= r_next; q_s_ff <= q_next; n_s_ff <= n_next; t_s_ff <= t_ff[s];
         end
      end
      assign v_ff[s+1] = v_s_ff;
      assign r_ff[s+1] = r_s_ff;
      assign q_ff[s+1] = q_s_ff;
      assign n_ff[s+1] = n_s_ff;
      assign t_ff[s+1] = t_s_ff;
   end

   // Final stage: fallback select and class.
   logic [15:0] g;
   assign g = (t_ff[Stages] == '0) ? {cfg.fallback_seconds, 8'd0} : q_ff[Stages];

   always_ff @(posedge clock) begin
      if (reset) v_out_ff <= 1'b0;
      else if (advance) v_out_ff <= v_ff[Stages];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         green_ff <= g;
         if (g < {cfg.short_limit, 8'd0}) cls_ff <= ClassShort;
         else if (g < {cfg.medium_limit, 8'd0}) cls_ff <= ClassMedium;
         else cls_ff <= ClassLong;
      end
   end

   assign out_valid = v_out_ff;
   assign green = green_ff;
   assign cls = cls_ff;
endmodule
`default_nettype wire

@@ test/fuzzy_green_time_controller_tb.sv @@
// Self-checking testbench for the fuzzy green-time controller.
`default_nettype none
module fuzzy_green_time_controller_tb;
   import fgtc_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // traffic_density, wait_seconds
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // green_time, duration_class, zero fill
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   typedef struct packed {
      logic [1:0]  duration_class;
      logic [15:0] green_time;
   } green_result_type;

   green_result_type expected_greens[$];
   int            mismatch_count = 0;
   int            send_idle_pct = 0;
   int            take_idle_pct = 0;
   logic [7:0]    cfg_regs [0:5] = '{25, 45, 70, 30, 35, 60};

   fuzzy_green_time_controller u_dut (.*);

   // Free-running clock.
   initial begin
      forever #10 clock = ~clock;
   end

   // Hard limit on simulated run time.
   initial begin
      #4000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // One membership ramp, truncated toward zero.
   function automatic int ramp_grade(int num, int den);
      return (num * GradeOne) / den;
   endfunction

   // Low, medium and high grades of one input.
   function automatic void grade_input(int x, int lf, int lz, int m0, int mp, int m1,
                                       int h0, int hf, output int g[3]);
      g = '{0, 0, 0};
      if (x <= lf) g[0] = GradeOne;
      else if (x < lz) g[0] = ramp_grade(lz - x, lz - lf);
      if (x > m0 && x <= mp) g[1] = ramp_grade(x - m0, mp - m0);
      else if (x > mp && x < m1) g[1] = ramp_grade(m1 - x, m1 - mp);
      if (x > h0 && x < hf) g[2] = ramp_grade(x - h0, hf - h0);
      else if (x >= hf) g[2] = GradeOne;
   endfunction

   function automatic int min2(int a, int b);
      return a < b ? a : b;
   endfunction

   function automatic int max2(int a, int b);
      return a > b ? a : b;
   endfunction

   // Green time and class for one density and wait pair.
   function automatic green_result_type predict_green(logic [7:0] density, logic [7:0] waiting);
      int d[3];
      int w[3];
      int gs, gm, gl, total;
      longint num, green;
      green_result_type r;
      grade_input(density, 25, 40, 30, 50, 70, 60, 75, d);
      grade_input(waiting, 20, 40, 30, 55, 80, 70, 90, w);
      gs = max2(max2(min2(d[0], w[0]), min2(d[0], w[1])), min2(d[1], w[0]));
      gm = max2(max2(min2(d[1], w[1]), min2(d[1], w[2])),
                max2(min2(d[2], w[0]), min2(d[0], w[2])));
      gl = max2(min2(d[2], w[1]), min2(d[2], w[2]));
      total = gs + gm + gl;
      if (total == 0) begin
         green = longint'(cfg_regs[RegFallback]) * 256;
      end else begin
         num = (longint'(cfg_regs[RegCentreShort]) * gs + longint'(cfg_regs[RegCentreMedium]) * gm
                + longint'(cfg_regs[RegCentreLong]) * gl) * 256;
         green = (num + total / 2) / total;
      end
      r.green_time = green[15:0];
      if (r.green_time < 16'(cfg_regs[RegShortLimit]) * 256) r.duration_class = ClassShort;
      else if (r.green_time < 16'(cfg_regs[RegMediumLimit]) * 256) r.duration_class = ClassMedium;
      else r.duration_class = ClassLong;
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("error at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Result checker with random back-pressure.
   always @(posedge clock) begin
      green_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_greens.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata[15:0], 0);
         end else begin
            want = expected_greens.pop_front();
            if (rsp_tdata[15:0] !== want.green_time)
               report_mismatch("green_time", rsp_tdata[15:0], want.green_time);
            if (rsp_tdata[17:16] !== want.duration_class)
               report_mismatch("duration_class", rsp_tdata[17:16], want.duration_class);
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= take_idle_pct);
   end

   // Sends one request, idling first at random. The valid stays high after
   // acceptance so that requests can follow back to back.
   task automatic send_request(logic [7:0] density, logic [7:0] waiting);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {waiting, density};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_greens.push_back(predict_green(density, waiting));
      @(negedge clock);
   endtask

   // Stops sending, waits for all results, then for the pipeline to settle.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_greens.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   // Writes one register through the setup and access phases.
   task automatic write_register(logic [2:0] index, logic [7:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= 5'(index) << 2;
      csr_pwdata <= {16'($urandom_range(16'hffff)), 8'h00, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      cfg_regs[index] = value;
      @(negedge clock);
   endtask

   task automatic load_config(logic [7:0] cs, cm, cl, fb, sl, ml);
      drain_results();
      write_register(RegCentreShort, cs);
      write_register(RegCentreMedium, cm);
      write_register(RegCentreLong, cl);
      write_register(RegFallback, fb);
      write_register(RegShortLimit, sl);
      write_register(RegMediumLimit, ml);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Membership breakpoints and field extremes.
   task automatic test_directed();
      logic [7:0] points[12] = '{0, 20, 25, 30, 40, 50, 55, 60, 75, 90, 128, 255};
      foreach (points[i]) send_request(points[i], points[(i * 5) % 12]);
      send_request(8'd35, 8'd40);
      send_request(8'd50, 8'd255);
      send_request(8'd255, 8'd0);
      send_request(8'd255, 8'd255);
      send_request(8'd0, 8'd0);
      send_request(8'd65, 8'd60);
      send_request(8'd45, 8'd85);
      send_request(8'd35, 8'd35);
   endtask

   // Random pairs, mostly in the active ranges of the memberships.
   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) == 0)
            send_request(8'($urandom_range(255)), 8'($urandom_range(255)));
         else
            send_request(8'($urandom_range(100)), 8'($urandom_range(100)));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 37;
      take_idle_pct = 46;
      test_directed();
      test_random(500);

      // Extreme register values, with swapped class limits.
      load_config(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      test_directed();
      load_config(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
      test_random(200);
      send_idle_pct = 46;
      take_idle_pct = 37;
      load_config(8'd255, 8'd128, 8'd1, 8'd200, 8'd100, 8'd20);
      test_random(400);
      send_idle_pct = 0;
      take_idle_pct = 0;
      load_config(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(80)), 8'($urandom_range(255)));
      test_random(300);
      load_config(8'd25, 8'd45, 8'd70, 8'd30, 8'd35, 8'd60);
      test_random(350);
      drain_results();

      if (mismatch_count == 0 && expected_greens.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
`default_nettype wire
